// ===== sv/arp_pkg.sv =====
// Package for the ARP cache engine: constants, codes and state type.
`timescale 1ns / 1ps
`default_nettype none
package arp_pkg;
   localparam int unsigned CacheEntries = 32;
   localparam logic [9:0] LifetimeReset = 10'd600;
   localparam logic [7:0] IntervalReset = 8'd3;
   localparam logic [10:0] MinFrameBytes = 11'd42;
   localparam logic [15:0] EtherTypeArp = 16'h0806;
   localparam logic [15:0] HwTypeEther = 16'h0001;
   localparam logic [15:0] ProtoTypeIpv4 = 16'h0800;
   localparam logic [7:0] HwLenMac = 8'd6;
   localparam logic [7:0] ProtoLenIpv4 = 8'd4;
   localparam logic [15:0] OpRequest = 16'd1;

   localparam logic [1:0] ActFrame = 2'd0;
   localparam logic [1:0] ActResolve = 2'd1;
   localparam logic [1:0] ActTick = 2'd2;

   localparam logic [1:0] KindReply = 2'd0;
   localparam logic [1:0] KindHit = 2'd1;
   localparam logic [1:0] KindRequest = 2'd2;
   localparam logic [1:0] KindPending = 2'd3;

   localparam logic [1:0] CsrLocalIp = 2'd0;
   localparam logic [1:0] CsrLocalMac = 2'd1;
   localparam logic [1:0] CsrLifetime = 2'd2;
   localparam logic [1:0] CsrInterval = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE,
      ST_APPLY,
      ST_READ,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== sv/arp_cache_engine.sv =====
// Top level of the ARP cache engine: cache store, scan sequencer and ports.
`timescale 1ns / 1ps
`default_nettype none
// How to use this block.
// Items arrive on the req_ ports and are taken at a clock edge where start is
// high and busy is low. An item is a received ARP frame, a resolve query or a
// tick, chosen by req_action. A result, when the item causes one, appears on
// the rsp_ ports for exactly one cycle with rsp_valid high; the receiver
// cannot stall it, so no result is ever held back.
// Every item that raises busy walks the cache one entry per cycle with a
// single shared compare unit: the walk finds the matching entry, the first
// free entry and the entry with the smallest remaining lifetime at the same
// time, or, for a tick, ages one entry per cycle. A frame or query then
// passes through the apply, read and done states to update the chosen entry
// and read its MAC, keeping busy high until the done state ends; a tick
// drops busy when its walk ends. A reply, request or pending result is
// registered in the apply state, a resolve hit in the done state.
// A dropped frame or an unknown action never raises busy.
// The csr_ channel writes local_ip, local_mac, entry_lifetime and
// probe_interval by index; it is always ready and is meant to be used while
// the block is idle. Reset clears all entries at once through their valid,
// probing and lifetime flip-flops and returns the registers to their reset
// values; no clearing pass is needed.
module arp_cache_engine #(
   parameter int unsigned CACHE_ENTRIES = arp_pkg::CacheEntries
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [10:0] req_frame_length,
   input  wire logic [15:0] req_ether_type,
   input  wire logic [15:0] req_hw_type,
   input  wire logic [15:0] req_proto_type,
   input  wire logic [7:0]  req_hw_len,
   input  wire logic [7:0]  req_proto_len,
   input  wire logic [15:0] req_opcode,
   input  wire logic [47:0] req_sender_mac,
   input  wire logic [31:0] req_sender_ip,
   input  wire logic [31:0] req_target_ip,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [47:0]      rsp_mac,
   output logic [31:0]      rsp_ip,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);
   import arp_pkg::*;

   localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int unsigned CntW = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CntW-1:0] LastCnt = CntW'(CACHE_ENTRIES - 1);

   // Configuration registers.
   logic [31:0] local_ip_ff;
   logic [47:0] local_mac_ff;
   logic [9:0]  lifetime_ff;
   logic [7:0]  interval_ff;

   // Cache store: per-entry flip-flops are read at the scan index, valid and probing also at the match index.
   logic [31:0] ent_ip_ff  [CACHE_ENTRIES];
   logic [9:0]  ent_ttl_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] ent_valid_ff;
   logic [CACHE_ENTRIES-1:0] ent_probe_ff;
   logic [47:0] ent_mac_mem [CACHE_ENTRIES];
   logic [47:0] mac_rd_ff;

   // Sequencer state and item capture.
   state_type   state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0]  act_ff;
   logic [31:0] key_ff;
   logic [47:0] smac_ff;
   logic        reply_ff;
   logic        hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic        free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic [IdxW-1:0] min_idx_ff, min_idx_in;
   logic [9:0]  min_ttl_ff, min_ttl_in;
   logic [IdxW-1:0] sel_ff;
   logic        hit_pend_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [47:0] rsp_mac_ff;
   logic [31:0] rsp_ip_ff;

   logic [IdxW-1:0] scan_idx;
   logic        frame_ok;
   logic        live;
   logic        apply_en;
   logic        sel_valid;
   logic        sel_probe;

   assign scan_idx = cnt_ff[IdxW-1:0];
   assign live     = ent_valid_ff[scan_idx] | ent_probe_ff[scan_idx];
   assign frame_ok = (req_frame_length >= MinFrameBytes) && (req_ether_type == EtherTypeArp)
                     && (req_hw_type == HwTypeEther) && (req_proto_type == ProtoTypeIpv4)
                     && (req_hw_len == HwLenMac) && (req_proto_len == ProtoLenIpv4);
   assign sel_valid = ent_valid_ff[hit_idx_ff];
   assign sel_probe = ent_probe_ff[hit_idx_ff];

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_mac   = rsp_mac_ff;
   assign rsp_ip    = rsp_ip_ff;

   // Next state and the scan's shared compare unit.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      min_idx_in  = min_idx_ff;
      min_ttl_in  = min_ttl_ff;
      apply_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in  = '0;
            hit_in  = 1'b0;
            free_in = 1'b0;
            min_idx_in = '0;
            min_ttl_in = '1;
            if (start) begin
               if (req_action == ActTick) begin
                  state_in = ST_AGE;
               end else if ((req_action == ActFrame && frame_ok) || req_action == ActResolve) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!hit_ff && live && ent_ip_ff[scan_idx] == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_idx;
            end
            if (!free_ff && !live) begin
               free_in     = 1'b1;
               free_idx_in = scan_idx;
            end
            if (cnt_ff == '0 || ent_ttl_ff[scan_idx] < min_ttl_ff) begin
               min_ttl_in = ent_ttl_ff[scan_idx];
               min_idx_in = scan_idx;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastCnt) begin
               state_in = ST_APPLY;
            end
         end
         ST_AGE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastCnt) begin
               state_in = ST_IDLE;
            end
         end
         ST_APPLY: begin
            apply_en = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
         lifetime_ff  <= LifetimeReset;
         interval_ff  <= IntervalReset;
         ent_valid_ff <= '0;
         ent_probe_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            ent_ip_ff[i]  <= '0;
            ent_ttl_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CsrLocalIp:  local_ip_ff  <= csr_wdata[31:0];
               CsrLocalMac: local_mac_ff <= csr_wdata;
               CsrLifetime: lifetime_ff  <= csr_wdata[9:0];
               CsrInterval: interval_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_AGE && live) begin
            if (ent_ttl_ff[scan_idx] <= 10'd1) begin
               ent_ttl_ff[scan_idx]   <= '0;
               ent_valid_ff[scan_idx] <= 1'b0;
               ent_probe_ff[scan_idx] <= 1'b0;
            end else begin
               ent_ttl_ff[scan_idx] <= ent_ttl_ff[scan_idx] - 10'd1;
            end
         end
         if (apply_en) begin
            if (act_ff == ActFrame) begin
               ent_ip_ff[sel_in_idx()]    <= key_ff;
               ent_valid_ff[sel_in_idx()] <= 1'b1;
               ent_probe_ff[sel_in_idx()] <= 1'b0;
               ent_ttl_ff[sel_in_idx()]   <= lifetime_ff;
               if (reply_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KindReply;
                  rsp_mac_ff   <= smac_ff;
                  rsp_ip_ff    <= key_ff;
               end
            end else if (!hit_ff) begin
               ent_ip_ff[sel_in_idx()]    <= key_ff;
               ent_valid_ff[sel_in_idx()] <= 1'b0;
               ent_probe_ff[sel_in_idx()] <= 1'b1;
               ent_ttl_ff[sel_in_idx()]   <= {2'b00, interval_ff};
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= KindRequest;
               rsp_mac_ff   <= '0;
               rsp_ip_ff    <= key_ff;
            end else if (!sel_valid && sel_probe) begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= KindPending;
               rsp_mac_ff   <= '0;
               rsp_ip_ff    <= key_ff;
            end
         end
         if (state_ff == ST_DONE && hit_pend_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff  <= KindHit;
            rsp_mac_ff   <= mac_rd_ff;
            rsp_ip_ff    <= key_ff;
         end
      end
   end

   // Entry chosen for the update: the match, else the first free entry, else
   // the one with the least lifetime left.
   function automatic logic [IdxW-1:0] sel_in_idx();
      logic [IdxW-1:0] r;
      r = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);
      return r;
   endfunction

   // Datapath registers without reset, and the MAC memory.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      min_idx_ff  <= min_idx_in;
      min_ttl_ff  <= min_ttl_in;
      if (state_ff == ST_IDLE && start) begin
         act_ff   <= req_action;
         key_ff   <= (req_action == ActFrame) ? req_sender_ip : req_target_ip;
         smac_ff  <= req_sender_mac;
         reply_ff <= (req_opcode == OpRequest) && (req_target_ip == local_ip_ff);
      end
      if (apply_en) begin
         sel_ff <= sel_in_idx();
         if (act_ff == ActFrame) begin
            ent_mac_mem[sel_in_idx()] <= smac_ff;
         end
      end
      mac_rd_ff <= ent_mac_mem[sel_ff];
   end

   // A resolve hit on a valid entry is reported only from the done state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_pend_ff <= 1'b0;
      end else if (apply_en) begin
         hit_pend_ff <= (act_ff == ActResolve) && hit_ff && sel_valid;
      end else if (state_ff == ST_DONE) begin
         hit_pend_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_done_hit: assert property (@(posedge clock) disable iff (reset)
      hit_pend_ff |-> (state_ff == ST_READ || state_ff == ST_DONE))
      else $error("pending hit outside the read and done states");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> busy)
      else $error("scan while not busy");
`endif
endmodule
`default_nettype wire

// ===== sim/arp_cache_engine_tb.sv =====
// Self-checking testbench for the ARP cache engine: directed table, then random traffic.
`timescale 1ns / 1ps
module arp_cache_engine_tb;
   import arp_pkg::*;

   // Action code that the block must ignore.
   localparam logic [1:0] ActUnknown = 2'd3;

   // How a directed row is checked: by the predictor, against a typed result,
   // or as a row that must cause no result at all.
   localparam int RowPredicted = 0;
   localparam int RowTypedResult = 1;
   localparam int RowTypedNone = 2;

   localparam int unsigned CycleLimit = 600000;
   localparam int unsigned DrainCycles = 45;

   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] frame_length;
      logic [15:0] ether_type;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
   } arp_item_t;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] mac;
      logic [31:0] ip;
   } arp_answer_t;

   typedef struct {
      arp_item_t   item;
      int          mode;
      arp_answer_t answer;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [10:0] req_frame_length = '0;
   logic [15:0] req_ether_type = '0;
   logic [15:0] req_hw_type = '0;
   logic [15:0] req_proto_type = '0;
   logic [7:0]  req_hw_len = '0;
   logic [7:0]  req_proto_len = '0;
   logic [15:0] req_opcode = '0;
   logic [47:0] req_sender_mac = '0;
   logic [31:0] req_sender_ip = '0;
   logic [31:0] req_target_ip = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [47:0] rsp_mac;
   logic [31:0] rsp_ip;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   arp_cache_engine u_top (
      .clock, .reset, .start, .busy,
      .req_action, .req_frame_length, .req_ether_type, .req_hw_type,
      .req_proto_type, .req_hw_len, .req_proto_len, .req_opcode,
      .req_sender_mac, .req_sender_ip, .req_target_ip,
      .rsp_valid, .rsp_kind, .rsp_mac, .rsp_ip,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The testbench's own picture of the cache and its registers.
   logic [31:0] own_ip;
   logic [47:0] own_mac;
   logic [9:0]  life_ticks;
   logic [7:0]  probe_ticks;
   logic [31:0] cache_ip [CacheEntries];
   logic [47:0] cache_mac [CacheEntries];
   logic [9:0]  cache_ttl [CacheEntries];
   logic        cache_live [CacheEntries];
   logic        cache_probe [CacheEntries];

   // Answers that the block still owes, oldest first.
   arp_answer_t owed_answers [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int find_entry_for(input logic [31:0] addr);
      for (int i = 0; i < CacheEntries; i++)
         if ((cache_live[i] || cache_probe[i]) && cache_ip[i] == addr) return i;
      return -1;
   endfunction

   // A free entry if there is one, otherwise the one closest to expiry.
   function automatic int claim_slot(input logic [31:0] addr);
      int pick;
      pick = -1;
      for (int i = 0; i < CacheEntries; i++)
         if (pick < 0 && !cache_live[i] && !cache_probe[i]) pick = i;
      if (pick < 0) begin
         pick = 0;
         for (int i = 1; i < CacheEntries; i++)
            if (cache_ttl[i] < cache_ttl[pick]) pick = i;
      end
      cache_ip[pick] = addr;
      cache_live[pick] = 1'b0;
      cache_probe[pick] = 1'b0;
      cache_ttl[pick] = '0;
      return pick;
   endfunction

   task automatic predict_answer(input arp_item_t it, output bit has, output arp_answer_t ans);
      int idx;
      has = 1'b0;
      ans = '0;
      case (it.action)
         ActFrame: begin
            if (it.frame_length >= MinFrameBytes && it.ether_type == EtherTypeArp &&
                it.hw_type == HwTypeEther && it.proto_type == ProtoTypeIpv4 &&
                it.hw_len == HwLenMac && it.proto_len == ProtoLenIpv4) begin
               idx = find_entry_for(it.sender_ip);
               if (idx < 0) idx = claim_slot(it.sender_ip);
               cache_mac[idx] = it.sender_mac;
               cache_live[idx] = 1'b1;
               cache_probe[idx] = 1'b0;
               cache_ttl[idx] = life_ticks;
               if (it.opcode == OpRequest && it.target_ip == own_ip) begin
                  has = 1'b1;
                  ans = '{KindReply, it.sender_mac, it.sender_ip};
               end
            end
         end
         ActResolve: begin
            has = 1'b1;
            idx = find_entry_for(it.target_ip);
            if (idx >= 0 && cache_live[idx]) ans = '{KindHit, cache_mac[idx], it.target_ip};
            else if (idx >= 0) ans = '{KindPending, 48'd0, it.target_ip};
            else begin
               idx = claim_slot(it.target_ip);
               cache_probe[idx] = 1'b1;
               cache_ttl[idx] = {2'b00, probe_ticks};
               ans = '{KindRequest, 48'd0, it.target_ip};
            end
         end
         ActTick: begin
            for (int i = 0; i < CacheEntries; i++) begin
               if (cache_live[i] || cache_probe[i]) begin
                  if (cache_ttl[i] != 0) cache_ttl[i]--;
                  if (cache_ttl[i] == 0) begin
                     cache_live[i] = 1'b0;
                     cache_probe[i] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Results cannot be held off, so every strobe is checked on the edge that ends it.
   always @(posedge clock) begin
      arp_answer_t want;
      if (!reset && rsp_valid) begin
         if (owed_answers.size() == 0) report($sformatf("unexpected result kind %0d", rsp_kind));
         else begin
            want = owed_answers.pop_front();
            if (rsp_kind !== want.kind)
               report($sformatf("kind %0d, wanted %0d", rsp_kind, want.kind));
            if (rsp_mac !== want.mac)
               report($sformatf("mac %h, wanted %h", rsp_mac, want.mac));
            if (rsp_ip !== want.ip)
               report($sformatf("ip %h, wanted %h", rsp_ip, want.ip));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("arp_cache_engine_tb: errors");
         $finish;
      end
   end

   // Sender burst state: items left in this burst before a random gap.
   int burst_left = 0;

   // Presents one item and returns on the edge at which it is taken. Start is
   // left high so that a following item can be presented on the same edge.
   task automatic send_item(input arp_item_t it, input int mode, input arp_answer_t typed);
      bit has;
      arp_answer_t ans;
      req_action <= it.action;
      req_frame_length <= it.frame_length;
      req_ether_type <= it.ether_type;
      req_hw_type <= it.hw_type;
      req_proto_type <= it.proto_type;
      req_hw_len <= it.hw_len;
      req_proto_len <= it.proto_len;
      req_opcode <= it.opcode;
      req_sender_mac <= it.sender_mac;
      req_sender_ip <= it.sender_ip;
      req_target_ip <= it.target_ip;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_answer(it, has, ans);
      if (mode == RowTypedResult) owed_answers.push_back(typed);
      else if (mode == RowPredicted && has) owed_answers.push_back(ans);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrLocalIp:  own_ip = value[31:0];
         CsrLocalMac: own_mac = value;
         CsrLifetime: life_ticks = value[9:0];
         CsrInterval: probe_ticks = value[7:0];
         default: ;
      endcase
   endtask

   // Lets every owed result arrive, then lets a silent item finish its walk.
   task automatic settle;
      start <= 1'b0;
      while (owed_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic arp_item_t good_frame(input logic [15:0] op, input logic [47:0] smac,
                                            input logic [31:0] sip, input logic [31:0] tip);
      arp_item_t it;
      it = '0;
      it.action = ActFrame;
      it.frame_length = MinFrameBytes;
      it.ether_type = EtherTypeArp;
      it.hw_type = HwTypeEther;
      it.proto_type = ProtoTypeIpv4;
      it.hw_len = HwLenMac;
      it.proto_len = ProtoLenIpv4;
      it.opcode = op;
      it.sender_mac = smac;
      it.sender_ip = sip;
      it.target_ip = tip;
      return it;
   endfunction

   function automatic arp_item_t query(input logic [1:0] act, input logic [31:0] tip);
      arp_item_t it;
      it = '0;
      it.action = act;
      it.target_ip = tip;
      return it;
   endfunction

   function automatic dir_row_t row(input arp_item_t it, input int mode, input arp_answer_t ans);
      dir_row_t r;
      r.item = it;
      r.mode = mode;
      r.answer = ans;
      return r;
   endfunction

   // Random traffic draws addresses from a small pool so that hits, probes
   // and evictions of a full cache all happen often.
   logic [31:0] ip_pool [40];

   function automatic arp_item_t random_item();
      arp_item_t it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         it = good_frame(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2)),
                         {16'($urandom), 32'($urandom)},
                         ip_pool[$urandom_range(0, 39)],
                         $urandom_range(0, 1) ? own_ip : ip_pool[$urandom_range(0, 39)]);
         it.frame_length = 11'($urandom_range(MinFrameBytes, 2047));
         // A fifth of the frames are broken in one header field.
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0: it.frame_length = 11'($urandom_range(0, MinFrameBytes - 1));
               1: it.ether_type = 16'($urandom);
               2: it.hw_type = 16'($urandom);
               3: it.proto_type = 16'($urandom);
               4: it.hw_len = 8'($urandom);
               default: it.proto_len = 8'($urandom);
            endcase
         end
      end else if (pick < 78) begin
         it = query(ActResolve, $urandom_range(0, 15) == 0 ? 32'($urandom)
                                                           : ip_pool[$urandom_range(0, 39)]);
      end else if (pick < 96) begin
         it = query(ActTick, 32'($urandom));
      end else begin
         it = {ActUnknown, 11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 32'($urandom),
               32'($urandom), 32'($urandom)};
      end
      return it;
   endfunction

   initial begin
      dir_row_t dir_tab [$];
      arp_item_t it;
      logic [31:0] addr_a;
      logic [47:0] mac_a;
      logic [47:0] cfg [4][4];

      own_ip = '0;
      own_mac = '0;
      life_ticks = LifetimeReset;
      probe_ticks = IntervalReset;
      for (int i = 0; i < CacheEntries; i++) begin
         cache_ip[i] = '0;
         cache_mac[i] = '0;
         cache_ttl[i] = '0;
         cache_live[i] = 1'b0;
         cache_probe[i] = 1'b0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run at the reset settings (local_ip is zero).
      addr_a = 32'hC0A8_0001;
      mac_a = 48'h0200_5E10_2233;
      dir_tab.push_back(row(query(ActResolve, addr_a), RowTypedResult,
                            '{KindRequest, 48'd0, addr_a}));
      dir_tab.push_back(row(query(ActResolve, addr_a), RowTypedResult,
                            '{KindPending, 48'd0, addr_a}));
      // Three ticks use up the default probe interval, so the probe expires.
      repeat (3) dir_tab.push_back(row(query(ActTick, '0), RowTypedNone, '0));
      dir_tab.push_back(row(query(ActResolve, addr_a), RowTypedResult,
                            '{KindRequest, 48'd0, addr_a}));
      // A request for our own address both learns the sender and is answered.
      dir_tab.push_back(row(good_frame(OpRequest, mac_a, addr_a, 32'd0), RowTypedResult,
                            '{KindReply, mac_a, addr_a}));
      dir_tab.push_back(row(query(ActResolve, addr_a), RowTypedResult,
                            '{KindHit, mac_a, addr_a}));
      it = good_frame(OpRequest, mac_a, 32'h0A00_0001, 32'd0);
      it.frame_length = MinFrameBytes - 11'd1;
      dir_tab.push_back(row(it, RowTypedNone, '0));
      // A reply opcode learns but is never answered.
      dir_tab.push_back(row(good_frame(16'd2, '1, '1, 32'd0), RowTypedNone, '0));
      for (int f = 0; f < 5; f++) begin
         it = good_frame(OpRequest, mac_a, 32'h0A00_0002, 32'd0);
         case (f)
            0: it.ether_type = 16'h0800;
            1: it.hw_type = 16'hFFFF;
            2: it.proto_type = 16'h86DD;
            3: it.hw_len = 8'hFF;
            default: it.proto_len = 8'd0;
         endcase
         dir_tab.push_back(row(it, RowTypedNone, '0));
      end
      dir_tab.push_back(row(query(ActResolve, '1), RowTypedResult, '{KindHit, '1, '1}));
      dir_tab.push_back(row('{ActUnknown, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1},
                            RowTypedNone, '0));
      it = good_frame(OpRequest, 48'd0, 32'd0, 32'd0);
      it.frame_length = '1;
      dir_tab.push_back(row(it, RowTypedResult, '{KindReply, 48'd0, 32'd0}));
      dir_tab.push_back(row(query(ActResolve, 32'd0), RowTypedResult, '{KindHit, 48'd0, 32'd0}));
      dir_tab.push_back(row(good_frame(OpRequest, mac_a, addr_a, 32'h0A0A_0A0A),
                            RowPredicted, '0));
      dir_tab.push_back(row(query(ActTick, '0), RowPredicted, '0));
      dir_tab.push_back(row(query(ActResolve, 32'h0A00_0002), RowPredicted, '0));
      foreach (dir_tab[r]) send_item(dir_tab[r].item, dir_tab[r].mode, dir_tab[r].answer);
      settle();

      // Register settings for the random phases: extremes, a zero lifetime
      // and interval, and random values.
      cfg[0] = '{'1, '1, 48'd1, 48'd1};
      cfg[1] = '{48'd0, 48'd0, 48'd1023, 48'd255};
      cfg[2] = '{{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                 48'd0, 48'd0};
      cfg[3] = '{{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                 48'($urandom_range(2, 40)), 48'($urandom_range(1, 8))};

      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CsrLocalIp, cfg[ph][0]);
         write_csr(CsrLocalMac, cfg[ph][1]);
         write_csr(CsrLifetime, cfg[ph][2]);
         write_csr(CsrInterval, cfg[ph][3]);
         csr_valid <= 1'b0;
         @(posedge clock);
         foreach (ip_pool[p]) ip_pool[p] = (p < 4) ? {28'($urandom), 4'(p)} : 32'($urandom);
         for (int n = 0; n < 190; n++) begin
            it = random_item();
            send_item(it, RowPredicted, '0);
         end
         settle();
      end

      if (owed_answers.size() != 0)
         report($sformatf("%0d results never arrived", owed_answers.size()));
      if (error_count == 0) $display("arp_cache_engine_tb: clean");
      else $display("arp_cache_engine_tb: errors");
      $finish;
   end
endmodule

// ===== arp_cache_engine.f =====
sv/arp_pkg.sv
sv/arp_cache_engine.sv
sim/arp_cache_engine_tb.sv
